/* rtl/core/iir_direct_form_filter_macros.svh */
// assertion macros for the iir direct form filter checker
`ifndef IIR_DIRECT_FORM_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_FILTER_MACROS_SVH

// antecedent at one edge, consequent at the next edge
`define IIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iir_direct_form_filter: check failed");

// antecedent and consequent at the same edge
`define IIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iir_direct_form_filter: check failed");

`endif

/* rtl/core/iir_pkg.sv */
// shared types, constants and microprogram for the iir direct form filter
package iir_pkg;

    localparam int COEF_W    = 24;
    localparam int FRAC_W    = 22;
    localparam int Y_W       = 32;
    localparam int OUT_W     = 24;
    localparam int PROD_W    = COEF_W + Y_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int RND_W     = ACC_W + 1 - FRAC_W;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    localparam int DEF_FORWARD_TAPS  = 3;
    localparam int DEF_FEEDBACK_TAPS = 3;
    localparam int DEF_SAMPLE_WIDTH  = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd5;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_B0    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_B1    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_B2    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_A1    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_A2    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SUM   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_STORE = 4'd7;
    localparam logic [STEP_W-1:0] STEP_GAIN  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LOAD  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd10;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2,
        COEF_GAIN
    } coef_sel_t;

    typedef enum logic [2:0] {
        DATA_X0,
        DATA_X1,
        DATA_X2,
        DATA_Y0,
        DATA_Y1
    } data_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LOAD_X,
        ACT_STORE_Y,
        ACT_EMIT
    } act_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_WAIT_OUT,
        COND_JUMP
    } cond_t;

    typedef struct packed {
        coef_sel_t         coef_sel;
        data_sel_t         data_sel;
        acc_op_t           acc_op;
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   go;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } status_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        begin
            case (step)
                STEP_IDLE:  w = '{COEF_B0, DATA_X0, ACC_HOLD, ACT_LOAD_X, COND_WAIT_IN, STEP_IDLE};
                STEP_B0:    w = '{COEF_B0, DATA_X0, ACC_HOLD, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_B1:    w = '{COEF_B1, DATA_X1, ACC_LOAD, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_B2:    w = '{COEF_B2, DATA_X2, ACC_ADD, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_A1:    w = '{COEF_A1, DATA_Y0, ACC_ADD, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_A2:    w = '{COEF_A2, DATA_Y1, ACC_SUB, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_SUM:   w = '{COEF_B0, DATA_X0, ACC_SUB, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_STORE: w = '{COEF_B0, DATA_X0, ACC_HOLD, ACT_STORE_Y, COND_NEXT, STEP_IDLE};
                STEP_GAIN:  w = '{COEF_GAIN, DATA_Y0, ACC_HOLD, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_LOAD:  w = '{COEF_B0, DATA_X0, ACC_LOAD, ACT_NONE, COND_NEXT, STEP_IDLE};
                STEP_EMIT:  w = '{COEF_B0, DATA_X0, ACC_HOLD, ACT_EMIT, COND_WAIT_OUT, STEP_IDLE};
                default:    w = '{COEF_B0, DATA_X0, ACC_HOLD, ACT_NONE, COND_JUMP, STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/core/iir_seq.sv */
// microcode sequencer: step counter, control rom and jump logic
module iir_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  iir_pkg::status_t status,
    output iir_pkg::ctrl_t   ctrl,
    output logic             in_ready
);
    import iir_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    ucode_t            uc;
    logic              go;

    assign uc = ucode_rom(pc_reg);

    always_comb
    begin
        case (uc.cond)
            COND_WAIT_IN:  go = status.in_valid;
            COND_WAIT_OUT: go = status.out_free;
            COND_NEXT:     go = 1'b1;
            COND_JUMP:     go = 1'b1;
            default:       go = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            case (uc.cond)
                COND_WAIT_OUT: pc_next = uc.target;
                COND_JUMP:     pc_next = uc.target;
                default:       pc_next = STEP_W'(pc_reg + 1'b1);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.uc   = uc;
    assign ctrl.go   = go;
    assign in_ready  = (uc.cond == COND_WAIT_IN);

endmodule

/* rtl/core/iir_dp.sv */
// datapath: coefficient registers, histories, shared multiplier, accumulator, output register
module iir_dp #(
    parameter int FORWARD_TAPS  = iir_pkg::DEF_FORWARD_TAPS,
    parameter int FEEDBACK_TAPS = iir_pkg::DEF_FEEDBACK_TAPS,
    parameter int SAMPLE_WIDTH  = iir_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [iir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iir_pkg::COEF_W-1:0]    cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]       in_sample,
    input  iir_pkg::ctrl_t                ctrl,
    output logic                          out_free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iir_pkg::OUT_W-1:0]     out_data
);
    import iir_pkg::*;

    localparam logic signed [ACC_W:0]    RND_HALF  = (ACC_W+1)'(1) <<< (FRAC_W - 1);
    localparam logic signed [RND_W-1:0]  Y_HI      = (RND_W'(1) <<< (Y_W - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0]  Y_LO      = ~Y_HI;
    localparam logic signed [RND_W-1:0]  O_HI      = (RND_W'(1) <<< (OUT_W - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0]  O_LO      = ~O_HI;
    localparam logic [COEF_W-1:0]        GAIN_ONE  = COEF_W'(1) << FRAC_W;

    logic signed [COEF_W-1:0]       coef_b0_reg;
    logic signed [COEF_W-1:0]       coef_b1_reg;
    logic signed [COEF_W-1:0]       coef_b2_reg;
    logic signed [COEF_W-1:0]       coef_a1_reg;
    logic signed [COEF_W-1:0]       coef_a2_reg;
    logic signed [COEF_W-1:0]       gain_reg;
    logic signed [SAMPLE_WIDTH-1:0] x0_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x2_reg;
    logic signed [Y_W-1:0]          y0_reg;
    logic signed [Y_W-1:0]          y1_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic                           out_valid_reg;
    logic [OUT_W-1:0]               out_data_reg;

    logic signed [COEF_W-1:0]       mul_a;
    logic signed [Y_W-1:0]          mul_b;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W:0]          rnd_sum;
    logic signed [RND_W-1:0]        rnd_val;
    logic signed [Y_W-1:0]          y_sat;
    logic [OUT_W-1:0]               o_sat;
    logic                           emit;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= '0;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            gain_reg    <= GAIN_ONE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_B0:   coef_b0_reg <= cfg_data;
                CFG_B1:   coef_b1_reg <= cfg_data;
                CFG_B2:   coef_b2_reg <= cfg_data;
                CFG_A1:   coef_a1_reg <= cfg_data;
                CFG_A2:   coef_a2_reg <= cfg_data;
                CFG_GAIN: gain_reg    <= cfg_data;
                default:  ;
            endcase
        end
    end

    // operand select, unused taps read as zero
    always_comb
    begin
        case (ctrl.uc.coef_sel)
            COEF_B0:   mul_a = coef_b0_reg;
            COEF_B1:   mul_a = (FORWARD_TAPS > 1) ? coef_b1_reg : '0;
            COEF_B2:   mul_a = (FORWARD_TAPS > 2) ? coef_b2_reg : '0;
            COEF_A1:   mul_a = (FEEDBACK_TAPS > 1) ? coef_a1_reg : '0;
            COEF_A2:   mul_a = (FEEDBACK_TAPS > 2) ? coef_a2_reg : '0;
            COEF_GAIN: mul_a = gain_reg;
            default:   mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.uc.data_sel)
            DATA_X0: mul_b = Y_W'(x0_reg);
            DATA_X1: mul_b = Y_W'(x1_reg);
            DATA_X2: mul_b = Y_W'(x2_reg);
            DATA_Y0: mul_b = y0_reg;
            DATA_Y1: mul_b = y1_reg;
            default: mul_b = '0;
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        case (ctrl.uc.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // round half up from q.22, then clamp
    assign rnd_sum = (ACC_W+1)'(acc_reg) + RND_HALF;
    assign rnd_val = rnd_sum[ACC_W:FRAC_W];

    always_comb
    begin
        if (rnd_val > Y_HI)
        begin
            y_sat = Y_HI[Y_W-1:0];
        end
        else if (rnd_val < Y_LO)
        begin
            y_sat = Y_LO[Y_W-1:0];
        end
        else
        begin
            y_sat = rnd_val[Y_W-1:0];
        end
    end

    always_comb
    begin
        if (rnd_val > O_HI)
        begin
            o_sat = O_HI[OUT_W-1:0];
        end
        else if (rnd_val < O_LO)
        begin
            o_sat = O_LO[OUT_W-1:0];
        end
        else
        begin
            o_sat = rnd_val[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (emit)
        begin
            out_data_reg <= o_sat;
        end
    end

    // sample and output histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_reg <= '0;
            x1_reg <= '0;
            x2_reg <= '0;
            y0_reg <= '0;
            y1_reg <= '0;
        end
        else if (ctrl.go)
        begin
            if (ctrl.uc.act == ACT_LOAD_X)
            begin
                x0_reg <= in_sample;
                x1_reg <= x0_reg;
                x2_reg <= x1_reg;
            end
            if (ctrl.uc.act == ACT_STORE_Y)
            begin
                y0_reg <= y_sat;
                y1_reg <= y0_reg;
            end
        end
    end

    assign emit     = ctrl.go && (ctrl.uc.act == ACT_EMIT);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/iir_direct_form_filter.sv */
// Second-order direct form I IIR filter, Q2.22 coefficients and gain, run by a
// microcoded sequencer over one shared 24x32 multiplier. A sample is taken in one
// accept step and then worked through ten program steps (five products into the
// accumulator, rounding and storing the feedback value, one gain product, rounding
// to the output), the last of which puts the result in the output register. No new
// sample is accepted before the program is back at its idle step, and the next one
// is accepted as soon as the program is back there, while the result waits in the
// output register; the emit step holds only if the previous word is still untaken.
// Coefficient writes belong in idle time between samples.
module iir_direct_form_filter #(
    parameter int FORWARD_TAPS  = iir_pkg::DEF_FORWARD_TAPS,
    parameter int FEEDBACK_TAPS = iir_pkg::DEF_FEEDBACK_TAPS,
    parameter int SAMPLE_WIDTH  = iir_pkg::DEF_SAMPLE_WIDTH,
    localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W  = ((iir_pkg::OUT_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [iir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iir_pkg::COEF_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_TDATA_W-1:0]         s_axis_tdata,   // sample_in
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_TDATA_W-1:0]        m_axis_tdata    // sample_out
);
    import iir_pkg::*;

    status_t          status;
    ctrl_t            ctrl;
    logic             out_free;
    logic [OUT_W-1:0] out_data;

    assign status.in_valid = s_axis_tvalid;
    assign status.out_free = out_free;

    iir_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (s_axis_tready)
    );

    iir_dp #(
        .FORWARD_TAPS  (FORWARD_TAPS),
        .FEEDBACK_TAPS (FEEDBACK_TAPS),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .ctrl      (ctrl),
        .out_free  (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_data);

endmodule

/* rtl/core/iir_checker.sv */
// port-level checks for the iir direct form filter, bound to the top level
`include "iir_direct_form_filter_macros.svh"

module iir_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [iir_pkg::OUT_W-1:0]  m_axis_tdata
);
    `IIR_ASSERT_NEXT(a_one_word_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `IIR_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))
    `IIR_ASSERT_NOW(a_busy_after_accept, $past(rst_n, 2) && $past(rst_n) && $past(s_axis_tvalid && s_axis_tready, 2), !s_axis_tready)
    `IIR_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind iir_direct_form_filter iir_checker u_iir_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
